[rtl/annexb_pkg.sv]
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared constants, types and codes of the avcC/hvcC to Annex B converter.
// ----------------------------------------------------------------------------
package annexb_pkg;

  localparam int SCAN_STARTS       = 4;
  localparam int HVCC_HEADER_BYTES = 22;
  localparam int AVCC_LEN_POS      = 4;
  localparam int WIN_BYTES         = SCAN_STARTS + 2;
  localparam int MAX_DATA          = (WIN_BYTES > 4) ? WIN_BYTES : 4;
  localparam int CNT_W             = $clog2(MAX_DATA + 2);
  localparam int POS_W             = 17;
  localparam logic [POS_W-1:0] CNT_MAX = {POS_W{1'b1}};

  localparam logic [1:0] MODE_AVC  = 2'd0;
  localparam logic [1:0] MODE_HEVC = 2'd1;
  localparam logic [1:0] MODE_COPY = 2'd2;

  localparam logic [7:0] RECORD_TAG = 8'h01;
  localparam logic [7:0] SPS_MASK   = 8'h1f;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_HDR     = 4'd1,
    PH_COUNT   = 4'd2,
    PH_PPSCNT  = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_TYPE    = 4'd7,
    PH_NUM_HI  = 4'd8,
    PH_NUM_LO  = 4'd9,
    PH_DONE    = 4'd10,
    PH_SCAN    = 4'd11,
    PH_COPY    = 4'd12,
    PH_FAIL    = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSC  = 2'd1,
    ST_SHORT = 2'd2,
    ST_TRUNC = 2'd3
  } status_e;

  // group of result words produced by one input word
  typedef struct packed {
    logic                       load;
    logic [MAX_DATA-1:0][7:0]   data;
    logic [CNT_W-1:0]           data_cnt;
    logic                       stat;
    logic [2:0]                 len_size;
    logic [POS_W-1:0]           size;
    status_e                    status;
  } bundle_t;

endpackage

[rtl/annexb_in_if.sv]
// ----------------------------------------------------------------------------
// annexb_in_if
// Input channel: one extradata byte per word with a last flag.
// ----------------------------------------------------------------------------
interface annexb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/annexb_out_if.sv]
// ----------------------------------------------------------------------------
// annexb_out_if
// Output channel: Annex B bytes and the final status word.
// ----------------------------------------------------------------------------
interface annexb_out_if;
  import annexb_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             is_status;
  logic [POS_W-1:0] out_size;
  logic [2:0]       length_size;
  logic [1:0]       status;
  logic             last_of_run;

  modport source (output valid, output out_byte, output is_status, output out_size,
                  output length_size, output status, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_status, input out_size,
                  input length_size, input status, input last_of_run, output ready);
endinterface

[rtl/avcc_hvcc_to_annexb_converter.sv]
// ----------------------------------------------------------------------------
// avcc_hvcc_to_annexb_converter
// Converts avcC/hvcC codec extradata to Annex B start-code form.
// ----------------------------------------------------------------------------
// The first result word of a byte appears in the cycle after the byte is accepted.
// Throughput, while the output is ready: one byte per cycle while each byte
//   yields at most one word; a byte with more words (start code, scan flush,
//   status) holds the input as the result register drains one word per cycle.
// Reset: asynchronous, clears parser state and result word count; mode is H.264.
module avcc_hvcc_to_annexb_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_wdata_i,
  annexb_in_if.sink    in_i,
  annexb_out_if.source out_o
);
  import annexb_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic       take;
  bundle_t    bnd;

  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AVC;
    end else begin
      mode_q <= mode_d;
    end
  end

  annexb_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .take_i (take),
    .in_i   (in_i),
    .bnd_o  (bnd)
  );

  annexb_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bnd_i  (bnd),
    .take_o (take),
    .out_o  (out_o)
  );

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !(out_o.ready && out_o.last_of_run) |-> !in_i.ready)
    else $error("input taken while result group pending");

  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.in_last |=> out_o.valid)
    else $error("no result after final byte");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_status |-> out_o.last_of_run && out_o.out_byte == 8'h00)
    else $error("status word malformed");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.length_size >= 3'd1 && out_o.length_size <= 3'd4)
    else $error("length size out of range");

endmodule

[rtl/annexb_parser.sv]
// ----------------------------------------------------------------------------
// annexb_parser
// Record parser: walks avcC/hvcC structure, scans for start codes and builds
// the group of result words for each accepted byte.
// ----------------------------------------------------------------------------
module annexb_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic                take_i,
  annexb_in_if.sink           in_i,
  output annexb_pkg::bundle_t bnd_o
);
  import annexb_pkg::*;

  phase_e                   phase_q, phase_d, phase_nx;
  logic                     hevc_q, hevc_d;
  logic                     second_q, second_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [15:0]              list_q, list_d;
  logic [7:0]               array_q, array_d;
  logic [15:0]              payload_q, payload_d;
  logic [POS_W-1:0]         total_q, total_d;
  logic [2:0]               nal_len_q, nal_len_d, nal_len_nx;
  logic [WIN_BYTES-1:0][7:0] win_q, win_d, win_new;

  logic                     fire;
  logic [7:0]               in_b;
  logic                     hit;
  logic                     scan_emit;
  logic                     hdr_end;
  logic [15:0]              list_lo;
  logic [15:0]              pay_lo;
  logic [15:0]              pay_dec;
  logic                     copy_first;
  phase_e                   list_end_ph, nal_done_ph;
  logic [CNT_W-1:0]         cnt;
  logic [POS_W:0]           sum;
  logic [POS_W-1:0]         total_sat;

  assign in_i.ready = take_i;
  assign fire       = in_i.valid & take_i;
  assign in_b       = in_i.in_byte;

  assign hdr_end    = pos_q >= (hevc_q ? POS_W'(HVCC_HEADER_BYTES - 1) : POS_W'(AVCC_LEN_POS));
  assign list_lo    = {list_q[15:8], in_b};
  assign pay_lo     = {payload_q[15:8], in_b};
  assign pay_dec    = payload_q - 16'd1;
  assign copy_first = mode_i >= MODE_COPY;

  assign list_end_ph = hevc_q ? ((array_q != 8'd0) ? PH_TYPE : PH_DONE)
                              : (!second_q ? PH_PPSCNT : PH_DONE);
  assign nal_done_ph = (list_q != 16'd0) ? PH_LEN_HI : list_end_ph;

  always_comb begin
    for (int i = 0; i < WIN_BYTES; i++) begin
      win_new[i] = ((phase_q == PH_FIRST || phase_q == PH_SCAN) && pos_q == POS_W'(i))
                   ? in_b : win_q[i];
    end
    hit = 1'b0;
    for (int p = 2; p < WIN_BYTES; p++) begin
      if (pos_q == POS_W'(p) && win_new[p-2] == 8'h00 && win_new[p-1] == 8'h00 &&
          win_new[p] == 8'h01) begin
        hit = 1'b1;
      end
    end
  end

  assign scan_emit = (phase_q == PH_SCAN) && hit && !(pos_q == POS_W'(2) && in_i.in_last);

  // next state
  always_comb begin
    phase_nx = phase_q;
    case (phase_q)
      PH_FIRST: begin
        if (copy_first) phase_nx = PH_COPY;
        else if (in_b == RECORD_TAG) phase_nx = PH_HDR;
        else phase_nx = PH_SCAN;
      end
      PH_HDR:     if (hdr_end) phase_nx = PH_COUNT;
      PH_COUNT: begin
        if (hevc_q) phase_nx = (in_b == 8'd0) ? PH_DONE : PH_TYPE;
        else phase_nx = ((in_b & SPS_MASK) == 8'd0) ? PH_PPSCNT : PH_LEN_HI;
      end
      PH_PPSCNT:  phase_nx = (in_b == 8'd0) ? PH_DONE : PH_LEN_HI;
      PH_TYPE:    phase_nx = PH_NUM_HI;
      PH_NUM_HI:  phase_nx = PH_NUM_LO;
      PH_NUM_LO:  phase_nx = (list_lo == 16'd0) ? list_end_ph : PH_LEN_HI;
      PH_LEN_HI:  phase_nx = PH_LEN_LO;
      PH_LEN_LO:  phase_nx = (pay_lo == 16'd0) ? nal_done_ph : PH_PAYLOAD;
      PH_PAYLOAD: if (pay_dec == 16'd0) phase_nx = nal_done_ph;
      PH_SCAN: begin
        if (scan_emit) phase_nx = PH_COPY;
        else if (!hit && pos_q == POS_W'(SCAN_STARTS + 1)) phase_nx = PH_FAIL;
      end
      default: phase_nx = phase_q;
    endcase
    phase_d = phase_q;
    if (fire) phase_d = in_i.in_last ? PH_FIRST : phase_nx;
  end

  // datapath and result group
  always_comb begin
    hevc_d     = hevc_q;
    second_d   = second_q;
    list_d     = list_q;
    array_d    = array_q;
    payload_d  = payload_q;
    nal_len_nx = nal_len_q;
    cnt        = '0;
    bnd_o      = '0;
    case (phase_q)
      PH_FIRST: begin
        if (copy_first) begin
          cnt           = CNT_W'(1);
          bnd_o.data[0] = in_b;
        end else if (in_b == RECORD_TAG) begin
          hevc_d = (mode_i == MODE_HEVC);
        end
      end
      PH_HDR:     if (hdr_end) nal_len_nx = 3'(in_b[1:0]) + 3'd1;
      PH_COUNT: begin
        if (hevc_q) array_d = in_b;
        else list_d = 16'(in_b & SPS_MASK);
      end
      PH_PPSCNT: begin
        second_d = 1'b1;
        list_d   = 16'(in_b);
      end
      PH_TYPE:    array_d = array_q - 8'd1;
      PH_NUM_HI:  list_d = {in_b, 8'h00};
      PH_NUM_LO:  list_d = list_lo;
      PH_LEN_HI: begin
        payload_d = {in_b, 8'h00};
        list_d    = list_q - 16'd1;
      end
      PH_LEN_LO: begin
        payload_d     = pay_lo;
        cnt           = CNT_W'(4);
        bnd_o.data[3] = 8'h01;
      end
      PH_PAYLOAD: begin
        payload_d     = pay_dec;
        cnt           = CNT_W'(1);
        bnd_o.data[0] = in_b;
      end
      PH_SCAN: begin
        if (scan_emit) begin
          cnt = CNT_W'(pos_q + POS_W'(1));
          for (int i = 0; i < WIN_BYTES; i++) bnd_o.data[i] = win_new[i];
        end
      end
      PH_COPY: begin
        cnt           = CNT_W'(1);
        bnd_o.data[0] = in_b;
      end
      default: cnt = '0;
    endcase

    sum       = {1'b0, total_q} + (POS_W + 1)'(cnt);
    total_sat = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[POS_W-1:0];

    bnd_o.load     = fire;
    bnd_o.data_cnt = cnt;
    bnd_o.stat     = in_i.in_last;
    bnd_o.len_size = nal_len_nx;
    bnd_o.size     = total_sat;
    if (phase_nx == PH_COPY || phase_nx == PH_DONE) bnd_o.status = ST_OK;
    else if (phase_nx == PH_SCAN || phase_nx == PH_FAIL)
      bnd_o.status = (pos_q <= POS_W'(2)) ? ST_SHORT : ST_NOSC;
    else if (pos_q == '0) bnd_o.status = ST_SHORT;
    else bnd_o.status = ST_TRUNC;

    pos_d     = pos_q;
    total_d   = total_q;
    nal_len_d = nal_len_q;
    win_d     = win_q;
    if (fire) begin
      if (in_i.in_last) begin
        hevc_d    = 1'b0;
        second_d  = 1'b0;
        list_d    = '0;
        array_d   = '0;
        payload_d = '0;
        pos_d     = '0;
        total_d   = '0;
        nal_len_d = 3'd4;
        win_d     = '0;
      end else begin
        pos_d     = (pos_q == CNT_MAX) ? CNT_MAX : pos_q + POS_W'(1);
        total_d   = total_sat;
        nal_len_d = nal_len_nx;
        win_d     = win_new;
      end
    end else begin
      hevc_d    = hevc_q;
      second_d  = second_q;
      list_d    = list_q;
      array_d   = array_q;
      payload_d = payload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FIRST;
      hevc_q    <= 1'b0;
      second_q  <= 1'b0;
      pos_q     <= '0;
      list_q    <= '0;
      array_q   <= '0;
      payload_q <= '0;
      total_q   <= '0;
      nal_len_q <= 3'd4;
      win_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hevc_q    <= hevc_d;
      second_q  <= second_d;
      pos_q     <= pos_d;
      list_q    <= list_d;
      array_q   <= array_d;
      payload_q <= payload_d;
      total_q   <= total_d;
      nal_len_q <= nal_len_d;
      win_q     <= win_d;
    end
  end

endmodule

[rtl/annexb_serializer.sv]
// ----------------------------------------------------------------------------
// annexb_serializer
// Result register: holds the word group of one input byte and hands it out
// one word per cycle while the output is ready.
// ----------------------------------------------------------------------------
module annexb_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  annexb_pkg::bundle_t bnd_i,
  output logic                take_o,
  annexb_out_if.source        out_o
);
  import annexb_pkg::*;

  bundle_t          bnd_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] tot_q, tot_d;
  logic             last;
  logic             fire;
  logic             is_data;
  logic [7:0]       data_b;

  assign last    = (idx_q + CNT_W'(1)) == tot_q;
  assign fire    = out_o.valid & out_o.ready;
  assign take_o  = (idx_q == tot_q) || (fire && last);
  assign is_data = idx_q < bnd_q.data_cnt;

  always_comb begin
    data_b = 8'h00;
    for (int i = 0; i < MAX_DATA; i++) begin
      if (idx_q == CNT_W'(i)) data_b = bnd_q.data[i];
    end
  end

  always_comb begin
    idx_d = idx_q;
    tot_d = tot_q;
    if (bnd_i.load) begin
      idx_d = '0;
      tot_d = bnd_i.data_cnt + CNT_W'(bnd_i.stat);
    end else if (fire) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  assign out_o.valid       = idx_q != tot_q;
  assign out_o.out_byte    = is_data ? data_b : 8'h00;
  assign out_o.is_status   = !is_data;
  assign out_o.out_size    = is_data ? '0 : bnd_q.size;
  assign out_o.length_size = bnd_q.len_size;
  assign out_o.status      = is_data ? ST_OK : bnd_q.status;
  assign out_o.last_of_run = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      tot_q <= '0;
    end else begin
      idx_q <= idx_d;
      tot_q <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_i.load) bnd_q <= bnd_i;
  end

endmodule
